FILE: rtl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, opcodes and constants of the differential drive odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

  // fixed point setup
  localparam int unsigned CORDIC_STEPS  = 24;
  localparam int unsigned POS_FRAC_BITS = 16;
  localparam int unsigned DIV_STEPS     = 58;
  localparam int unsigned CNT_W         = 6;
  localparam int unsigned CFG_IDX_W     = 8;

  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
  localparam logic [31:0] RAD_TO_BAM4 = 32'd341782638;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICK_SCALE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_TRACK  = 8'd1;

  // datapath opcodes
  localparam int unsigned OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD     = 5'd1;
  localparam logic [OP_W-1:0] OP_DL       = 5'd2;
  localparam logic [OP_W-1:0] OP_DR       = 5'd3;
  localparam logic [OP_W-1:0] OP_MEAN     = 5'd4;
  localparam logic [OP_W-1:0] OP_TH_LO    = 5'd5;
  localparam logic [OP_W-1:0] OP_TH_HI    = 5'd6;
  localparam logic [OP_W-1:0] OP_BAM_LO   = 5'd7;
  localparam logic [OP_W-1:0] OP_BAM_HI   = 5'd8;
  localparam logic [OP_W-1:0] OP_ROT_INIT = 5'd9;
  localparam logic [OP_W-1:0] OP_Q_INIT   = 5'd10;
  localparam logic [OP_W-1:0] OP_CSTEP    = 5'd11;
  localparam logic [OP_W-1:0] OP_CDONE    = 5'd12;
  localparam logic [OP_W-1:0] OP_X_LO     = 5'd13;
  localparam logic [OP_W-1:0] OP_X_HI     = 5'd14;
  localparam logic [OP_W-1:0] OP_Y_LO     = 5'd15;
  localparam logic [OP_W-1:0] OP_Y_HI     = 5'd16;
  localparam logic [OP_W-1:0] OP_HEAD     = 5'd17;
  localparam logic [OP_W-1:0] OP_VEL_INIT = 5'd18;
  localparam logic [OP_W-1:0] OP_DIV      = 5'd19;
  localparam logic [OP_W-1:0] OP_OUT      = 5'd20;

  typedef struct packed {
    logic signed [31:0] left_ticks;
    logic signed [31:0] right_ticks;
    logic [15:0]        interval_ms;
  } ddo_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        heading;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] lin_vel;
    logic signed [31:0] ang_vel;
    logic               vel_valid;
  } ddo_out_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [4:0]      idx;
  } ddo_cmd_t;

  typedef struct packed {
    logic d_nz;
  } ddo_stat_t;

  // arctangent of 2^-i as binary angle, 2^32 = 2*pi
  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      5'd24:   r = 32'h00000029;
      5'd25:   r = 32'h00000014;
      5'd26:   r = 32'h0000000A;
      5'd27:   r = 32'h00000005;
      5'd28:   r = 32'h00000003;
      5'd29:   r = 32'h00000001;
      5'd30:   r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/ddo_ctrl.sv
// ----------------------------------------------------------------------------
// ddo_ctrl
// Sequencer that steps the odometry datapath through one transaction.
// ----------------------------------------------------------------------------
module ddo_ctrl
  import ddo_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  ddo_stat_t stat_i,
  output ddo_cmd_t  cmd_o
);

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_DL       = 5'd1;
  localparam logic [4:0] ST_DR       = 5'd2;
  localparam logic [4:0] ST_MEAN     = 5'd3;
  localparam logic [4:0] ST_TH_LO    = 5'd4;
  localparam logic [4:0] ST_TH_HI    = 5'd5;
  localparam logic [4:0] ST_BAM_LO   = 5'd6;
  localparam logic [4:0] ST_BAM_HI   = 5'd7;
  localparam logic [4:0] ST_ROT_INIT = 5'd8;
  localparam logic [4:0] ST_ROT_STEP = 5'd9;
  localparam logic [4:0] ST_ROT_DONE = 5'd10;
  localparam logic [4:0] ST_X_LO     = 5'd11;
  localparam logic [4:0] ST_X_HI     = 5'd12;
  localparam logic [4:0] ST_Y_LO     = 5'd13;
  localparam logic [4:0] ST_Y_HI     = 5'd14;
  localparam logic [4:0] ST_HEAD     = 5'd15;
  localparam logic [4:0] ST_Q_INIT   = 5'd16;
  localparam logic [4:0] ST_Q_STEP   = 5'd17;
  localparam logic [4:0] ST_Q_DONE   = 5'd18;
  localparam logic [4:0] ST_VEL_INIT = 5'd19;
  localparam logic [4:0] ST_DIV      = 5'd20;
  localparam logic [4:0] ST_OUT      = 5'd21;

  localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_STEPS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(DIV_STEPS - 1);

  logic [4:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free    = !(out_valid_q && out_stall_i);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  // next state and command decode
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.op    = OP_NONE;
    cmd_o.idx   = cnt_q[4:0];
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_DL;
        end
      end
      ST_DL: begin
        cmd_o.op = OP_DL;
        state_d  = ST_DR;
      end
      ST_DR: begin
        cmd_o.op = OP_DR;
        state_d  = ST_MEAN;
      end
      ST_MEAN: begin
        cmd_o.op = OP_MEAN;
        state_d  = ST_TH_LO;
      end
      ST_TH_LO: begin
        cmd_o.op = OP_TH_LO;
        state_d  = ST_TH_HI;
      end
      ST_TH_HI: begin
        cmd_o.op = OP_TH_HI;
        state_d  = ST_BAM_LO;
      end
      ST_BAM_LO: begin
        cmd_o.op = OP_BAM_LO;
        state_d  = ST_BAM_HI;
      end
      ST_BAM_HI: begin
        cmd_o.op = OP_BAM_HI;
        state_d  = stat_i.d_nz ? ST_ROT_INIT : ST_HEAD;
      end
      ST_ROT_INIT: begin
        cmd_o.op = OP_ROT_INIT;
        cnt_d    = '0;
        state_d  = ST_ROT_STEP;
      end
      ST_ROT_STEP: begin
        cmd_o.op = OP_CSTEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CORDIC_LAST) begin
          state_d = ST_ROT_DONE;
        end
      end
      ST_ROT_DONE: begin
        cmd_o.op = OP_CDONE;
        state_d  = ST_X_LO;
      end
      ST_X_LO: begin
        cmd_o.op = OP_X_LO;
        state_d  = ST_X_HI;
      end
      ST_X_HI: begin
        cmd_o.op = OP_X_HI;
        state_d  = ST_Y_LO;
      end
      ST_Y_LO: begin
        cmd_o.op = OP_Y_LO;
        state_d  = ST_Y_HI;
      end
      ST_Y_HI: begin
        cmd_o.op = OP_Y_HI;
        state_d  = ST_HEAD;
      end
      ST_HEAD: begin
        cmd_o.op = OP_HEAD;
        state_d  = ST_Q_INIT;
      end
      ST_Q_INIT: begin
        cmd_o.op = OP_Q_INIT;
        cnt_d    = '0;
        state_d  = ST_Q_STEP;
      end
      ST_Q_STEP: begin
        cmd_o.op = OP_CSTEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CORDIC_LAST) begin
          state_d = ST_Q_DONE;
        end
      end
      ST_Q_DONE: begin
        cmd_o.op = OP_CDONE;
        state_d  = ST_VEL_INIT;
      end
      ST_VEL_INIT: begin
        cmd_o.op = OP_VEL_INIT;
        cnt_d    = '0;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          cmd_o.op    = OP_OUT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/ddo_datapath.sv
// ----------------------------------------------------------------------------
// ddo_datapath
// Pose state, shared 32x32 multiplier, CORDIC rotator and two-lane divider.
// ----------------------------------------------------------------------------
module ddo_datapath
  import ddo_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ddo_cmd_t             cmd_i,
  output ddo_stat_t            stat_o,
  input  ddo_in_t              in_data_i,
  output ddo_out_t             out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  localparam logic signed [33:0] Q30_POS = 34'sd1073741824;
  localparam logic signed [33:0] Q30_NEG = -34'sd1073741824;

  // configuration and pose state
  logic [31:0] tick_q;
  logic [23:0] itw_q;
  logic [31:0] last_l_q, last_r_q;
  logic [31:0] pose_x_q, pose_y_q, head_q;

  // per transaction working registers
  ddo_in_t     in_q;
  logic [48:0] dl_q, dr_q, d_q;
  logic [47:0] dmag_q;
  logic [49:0] diffmag_q;
  logic        th_neg_q;
  logic [57:0] thmag_q;
  logic [31:0] bam_q;
  logic [79:0] acc_q;
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic        flip_q;
  logic signed [31:0] c_q, s_q;
  logic [57:0] num_l_q, num_a_q, quo_l_q, quo_a_q;
  logic [15:0] rem_l_q, rem_a_q;
  logic        big_a_q;
  ddo_out_t    out_q;

  assign out_data_o  = out_q;
  assign stat_o.d_nz = (d_q != '0);

  // wheel delta, wrapping difference of counts
  logic [31:0] delta, delta_mag;
  logic [63:0] prod;
  logic [64:0] sprod;
  logic [31:0] mul_a, mul_b;
  assign delta = (cmd_i.op == OP_DR) ? 32'(in_q.right_ticks - last_r_q)
                                     : 32'(in_q.left_ticks - last_l_q);
  assign delta_mag = delta[31] ? 32'(~delta + 32'd1) : delta;
  assign sprod     = delta[31] ? 65'(~{1'b0, prod} + 65'd1) : {1'b0, prod};

  // mean travel and wheel difference
  logic [49:0] dsum, ddiff;
  logic [48:0] dabs;
  assign dsum  = {dl_q[48], dl_q} + {dr_q[48], dr_q};
  assign ddiff = {dr_q[48], dr_q} - {dl_q[48], dl_q};
  assign dabs  = dsum[49] ? 49'(~dsum[49:1] + 49'd1) : dsum[49:1];

  // signed heading change, low bits only feed the angle scaling
  logic [47:0] th48;
  assign th48 = th_neg_q ? 48'(~thmag_q[47:0] + 48'd1) : thmag_q[47:0];

  logic [31:0] c_abs, s_abs;
  assign c_abs = c_q[31] ? 32'(~c_q + 32'sd1) : c_q;
  assign s_abs = s_q[31] ? 32'(~s_q + 32'sd1) : s_q;

  // shared multiplier operand select
  always_comb begin
    mul_a = delta_mag;
    mul_b = tick_q;
    case (cmd_i.op)
      OP_TH_LO: begin
        mul_a = diffmag_q[31:0];
        mul_b = {8'd0, itw_q};
      end
      OP_TH_HI: begin
        mul_a = {14'd0, diffmag_q[49:32]};
        mul_b = {8'd0, itw_q};
      end
      OP_BAM_LO: begin
        mul_a = th48[31:0];
        mul_b = RAD_TO_BAM4;
      end
      OP_BAM_HI: begin
        mul_a = {16'd0, th48[47:32]};
        mul_b = RAD_TO_BAM4;
      end
      OP_X_LO: begin
        mul_a = dmag_q[31:0];
        mul_b = c_abs;
      end
      OP_X_HI: begin
        mul_a = {16'd0, dmag_q[47:32]};
        mul_b = c_abs;
      end
      OP_Y_LO: begin
        mul_a = dmag_q[31:0];
        mul_b = s_abs;
      end
      OP_Y_HI: begin
        mul_a = {16'd0, dmag_q[47:32]};
        mul_b = s_abs;
      end
      default: begin
        mul_a = delta_mag;
        mul_b = tick_q;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // high partial product joined to the stored low one
  logic [79:0] hi_sum;
  logic [31:0] inc, inc_x, inc_y;
  assign hi_sum = acc_q + {prod[47:0], 32'd0};
  assign inc    = hi_sum[61:30];
  assign inc_x  = (d_q[48] ^ c_q[31]) ? 32'(~inc + 32'd1) : inc;
  assign inc_y  = (d_q[48] ^ s_q[31]) ? 32'(~inc + 32'd1) : inc;

  // cordic start angle and quadrant fold
  logic [31:0] ang, ang_f;
  logic signed [33:0] z0;
  logic        fold;
  assign ang   = (cmd_i.op == OP_ROT_INIT) ? 32'((head_q - bam_q) << 1) : head_q;
  assign ang_f = ang + 32'h80000000;
  assign z0    = {{2{ang[31]}}, ang};
  assign fold  = (z0 > Q30_POS) || (z0 < Q30_NEG);

  // cordic micro rotation
  logic signed [33:0] xs, ys, at;
  assign xs = cx_q >>> cmd_i.idx;
  assign ys = cy_q >>> cmd_i.idx;
  assign at = $signed({2'b00, atan_bam(cmd_i.idx)});

  function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v,
                                                   input logic neg);
    logic signed [31:0] r;
    if (v > Q30_POS) begin
      r = 32'sd1073741824;
    end else if (v < Q30_NEG) begin
      r = -32'sd1073741824;
    end else begin
      r = v[31:0];
    end
    if (neg) begin
      r = -r;
    end
    return r;
  endfunction

  // divider lanes, one quotient bit per cycle
  logic [16:0] rsh_l, rsh_a;
  logic        qb_l, qb_a;
  assign rsh_l = {rem_l_q, num_l_q[57]};
  assign rsh_a = {rem_a_q, num_a_q[57]};
  assign qb_l  = (rsh_l >= {1'b0, in_q.interval_ms});
  assign qb_a  = (rsh_a >= {1'b0, in_q.interval_ms});

  function automatic logic [31:0] vel_sat(input logic [57:0] q, input logic neg,
                                          input logic big);
    logic [31:0] r;
    if (big || (q > 58'h7FFFFFFF)) begin
      r = neg ? 32'h80000000 : 32'h7FFFFFFF;
    end else begin
      r = neg ? 32'(~q[31:0] + 32'd1) : q[31:0];
    end
    if (neg && !big && q == 58'h80000000) begin
      r = 32'h80000000;
    end
    return r;
  endfunction

  // times 1000 as shifts
  function automatic logic [57:0] times_k(input logic [47:0] v);
    return ({v, 10'd0}) - ({10'd0, v} << 4) - ({10'd0, v} << 3);
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      itw_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_TICK_SCALE) begin
        tick_q <= cfg_data_i;
      end else if (cfg_index_i == REG_INV_TRACK) begin
        itw_q <= cfg_data_i[23:0];
      end
    end
  end

  // persistent pose and last counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_l_q <= '0;
      last_r_q <= '0;
      pose_x_q <= '0;
      pose_y_q <= '0;
      head_q   <= '0;
    end else begin
      case (cmd_i.op)
        OP_DR: begin
          last_l_q <= in_q.left_ticks;
          last_r_q <= in_q.right_ticks;
        end
        OP_X_HI: pose_x_q <= pose_x_q + inc_x;
        OP_Y_HI: pose_y_q <= pose_y_q + inc_y;
        OP_HEAD: head_q   <= head_q + bam_q;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: in_q <= in_data_i;
      OP_DL:   dl_q <= sprod[64:16];
      OP_DR:   dr_q <= sprod[64:16];
      OP_MEAN: begin
        d_q       <= dsum[49:1];
        dmag_q    <= dabs[47:0];
        th_neg_q  <= ddiff[49];
        diffmag_q <= ddiff[49] ? 50'(~ddiff + 50'd1) : ddiff;
      end
      OP_TH_LO, OP_BAM_LO, OP_X_LO, OP_Y_LO: acc_q <= {16'd0, prod};
      OP_TH_HI:  thmag_q <= hi_sum[73:16];
      OP_BAM_HI: bam_q   <= hi_sum[47:16];
      OP_ROT_INIT, OP_Q_INIT: begin
        cx_q   <= $signed({2'b00, CORDIC_GAIN});
        cy_q   <= '0;
        cz_q   <= fold ? $signed({{2{ang_f[31]}}, ang_f}) : z0;
        flip_q <= fold;
      end
      OP_CSTEP: begin
        if (!cz_q[33]) begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - at;
        end else begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + at;
        end
      end
      OP_CDONE: begin
        c_q <= clamp_q30(cx_q, flip_q);
        s_q <= clamp_q30(cy_q, flip_q);
      end
      OP_VEL_INIT: begin
        num_l_q <= times_k(dmag_q);
        num_a_q <= times_k(thmag_q[47:0]);
        big_a_q <= (thmag_q[57:48] != '0);
        rem_l_q <= '0;
        rem_a_q <= '0;
        quo_l_q <= '0;
        quo_a_q <= '0;
      end
      OP_DIV: begin
        num_l_q <= {num_l_q[56:0], 1'b0};
        num_a_q <= {num_a_q[56:0], 1'b0};
        rem_l_q <= qb_l ? 16'(rsh_l - {1'b0, in_q.interval_ms}) : rsh_l[15:0];
        rem_a_q <= qb_a ? 16'(rsh_a - {1'b0, in_q.interval_ms}) : rsh_a[15:0];
        quo_l_q <= {quo_l_q[56:0], qb_l};
        quo_a_q <= {quo_a_q[56:0], qb_a};
      end
      OP_OUT: begin
        out_q.pos_x     <= pose_x_q;
        out_q.pos_y     <= pose_y_q;
        out_q.heading   <= head_q;
        out_q.quat_z    <= s_q;
        out_q.quat_w    <= c_q;
        out_q.vel_valid <= (in_q.interval_ms != '0);
        if (in_q.interval_ms == '0) begin
          out_q.lin_vel <= '0;
          out_q.ang_vel <= '0;
        end else begin
          out_q.lin_vel <= vel_sat(quo_l_q, d_q[48], 1'b0);
          out_q.ang_vel <= vel_sat(quo_a_q, th_neg_q, big_a_q);
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/diff_drive_odometry.sv
// ----------------------------------------------------------------------------
// diff_drive_odometry
// Differential drive wheel odometry: encoder counts in, pose and speeds out.
// ----------------------------------------------------------------------------
// One transaction at a time. The time from acceptance to a valid result is
// set by two 24-step CORDIC passes through one shared rotator when the robot
// moved and one when the mean travel is zero, a 58-step radix-2 divider for
// the velocities and a single 32x32 multiplier that builds the heading, angle
// and position products in two halves. The next transaction is accepted
// while a finished result still waits at the output register. Configuration
// writes are taken at any time and must only be issued while idle.
module diff_drive_odometry
  import ddo_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ddo_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ddo_out_t             out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  ddo_cmd_t  cmd;
  ddo_stat_t stat;

  assign cfg_ready_o = 1'b1;

  // sequencer
  ddo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // arithmetic and state
  ddo_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

FILE: rtl/ddo_checker.sv
// ----------------------------------------------------------------------------
// ddo_checker
// Port level checks of the odometry block, bound to the top level.
// ----------------------------------------------------------------------------
module ddo_checker
  import ddo_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input ddo_out_t out_data_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // an accepted transaction stalls the input right after acceptance
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after transaction");

  // no velocity without a time base
  a_vel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.vel_valid |->
      out_data_o.lin_vel == 32'sd0 && out_data_o.ang_vel == 32'sd0)
    else $error("velocity reported with zero interval");

  // quaternion terms stay within unit range
  a_quat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_data_o.quat_z <= 32'sd1073741824 && out_data_o.quat_z >= -32'sd1073741824 &&
      out_data_o.quat_w <= 32'sd1073741824 && out_data_o.quat_w >= -32'sd1073741824)
    else $error("quaternion out of range");

endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (.*);
